[src/spd_pkg.sv]
// Package for the serial packet deframer: parse phases, status codes,
// register indexes and the structs passed between the parser and the top level.
// No dependencies.
`default_nettype none

package spd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned CfgAddrW = 2;

  // Parse phases
  localparam logic [PhaseW-1:0] PH_IDENT = 2'd0;
  localparam logic [PhaseW-1:0] PH_DESC  = 2'd1;
  localparam logic [PhaseW-1:0] PH_LEN   = 2'd2;
  localparam logic [PhaseW-1:0] PH_DATA  = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] ST_HEADER    = 3'd0;
  localparam logic [StatusW-1:0] ST_PAYLOAD   = 3'd1;
  localparam logic [StatusW-1:0] ST_EMPTY     = 3'd2;
  localparam logic [StatusW-1:0] ST_BAD_IDENT = 3'd3;
  localparam logic [StatusW-1:0] ST_TOO_LONG  = 3'd4;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_IDENT_FIRST  = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_IDENT_SECOND = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_MAX_PAYLOAD  = 2'd2;

  localparam logic [ByteW-1:0] MAX_PAYLOAD_RST = 8'hFF;

  typedef struct packed {
    logic [ByteW-1:0] ident_first;
    logic [ByteW-1:0] ident_second;
    logic [ByteW-1:0] max_payload;
  } spd_cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [ByteW-1:0]  ident;
    logic [ByteW-1:0]  desc;
    logic [ByteW-1:0]  len;
    logic [ByteW-1:0]  seen;
  } spd_state_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   ident;
    logic [ByteW-1:0]   desc;
    logic [ByteW-1:0]   len;
    logic [ByteW-1:0]   pbyte;
    logic [ByteW-1:0]   pindex;
    logic               last;
  } spd_result_t;

endpackage

`default_nettype wire

[src/serial_packet_deframer_unit.sv]
// Top level of the serial packet deframer: configuration registers, parser
// state registers and the result register. Depends on spd_pkg and spd_parser.
//
// The deframer takes one received byte per transaction and recovers packets of
// the form identifier, descriptor, length, payload. Every accepted byte yields
// exactly one result, registered on accept in a single output register. A new
// byte is taken in every cycle as long as the result register is empty or is
// being drained in the same cycle, so the sustained rate is one byte per clock;
// the only thing that sets it is the combinational parse step from the parser
// state registers to the result register. Each result reports a status
// (header byte, payload byte, empty packet, bad identifier, length too long),
// the held identifier, descriptor and length of the current packet, and for
// payload bytes the byte and its index; tlast marks the final payload byte and
// an empty packet. A bad identifier keeps the parser hunting for an identifier;
// a length above max_payload reports an error and restarts the parse.
// Configuration writes are always ready and should only be issued while the
// block is idle; writes to an unused index are dropped.
`default_nettype none

module serial_packet_deframer_unit
  import spd_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  // input byte stream
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [7:0]          in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [39:0]         out_tdata,  // [7:0] packet_ident, [15:8] descriptor,
                                          // [23:16] packet_len, [31:24] payload_byte,
                                          // [39:32] payload_index
  output logic [2:0]          out_tuser,  // [2:0] status
  output logic                out_tlast,  // last
  // configuration writes
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [CfgAddrW-1:0] cfg_addr,
  input  wire  [ByteW-1:0]    cfg_data
);

  spd_cfg_t    cfg_r;
  spd_state_t  state_r, state_nxt;
  spd_result_t res_r, res_nxt;
  logic        out_valid_r;
  logic        in_fire;

  // Accept while the result slot is free or draining this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  spd_parser u_parser (
    .state_i (state_r),
    .cfg_i   (cfg_r),
    .byte_i  (in_tdata),
    .state_o (state_nxt),
    .res_o   (res_nxt)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ident_first  <= '0;
      cfg_r.ident_second <= '0;
      cfg_r.max_payload  <= MAX_PAYLOAD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_IDENT_FIRST:  cfg_r.ident_first  <= cfg_data;
        REG_IDENT_SECOND: cfg_r.ident_second <= cfg_data;
        REG_MAX_PAYLOAD:  cfg_r.max_payload  <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Parser state: advance on every accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;  // phase resets to PH_IDENT, held fields to zero
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register: hold until taken, load on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.pindex, res_r.pbyte, res_r.len, res_r.desc, res_r.ident};
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.last;

endmodule

`default_nettype wire

[src/spd_parser.sv]
// One parse step of the deframer: next parser state and the result for one byte.
// Purely combinational; depends on spd_pkg.
`default_nettype none

module spd_parser
  import spd_pkg::*;
(
  input  wire spd_state_t  state_i,
  input  wire spd_cfg_t    cfg_i,
  input  wire [ByteW-1:0]  byte_i,
  output spd_state_t       state_o,
  output spd_result_t      res_o
);

  logic             ident_ok;
  logic [ByteW:0]   seen_inc;
  logic             data_end;

  assign ident_ok = (byte_i == cfg_i.ident_first) || (byte_i == cfg_i.ident_second);
  assign seen_inc = {1'b0, state_i.seen} + {{ByteW{1'b0}}, 1'b1};
  assign data_end = seen_inc >= {1'b0, state_i.len};

  always_comb begin
    state_o    = state_i;
    res_o      = '0;
    res_o.status = ST_HEADER;
    unique case (state_i.phase)
      PH_IDENT: begin
        state_o.ident = byte_i;
        if (ident_ok) begin
          state_o.phase = PH_DESC;
        end else begin
          res_o.status  = ST_BAD_IDENT;
          state_o.phase = PH_IDENT;
        end
      end
      PH_DESC: begin
        state_o.desc  = byte_i;
        state_o.phase = PH_LEN;
      end
      PH_LEN: begin
        state_o.len  = byte_i;
        state_o.seen = '0;
        if (byte_i == '0) begin
          res_o.status  = ST_EMPTY;
          res_o.last    = 1'b1;
          state_o.phase = PH_IDENT;
        end else if (byte_i > cfg_i.max_payload) begin
          res_o.status  = ST_TOO_LONG;
          state_o.phase = PH_IDENT;
        end else begin
          state_o.phase = PH_DATA;
        end
      end
      PH_DATA: begin
        res_o.status = ST_PAYLOAD;
        res_o.pbyte  = byte_i;
        res_o.pindex = state_i.seen;
        if (data_end) begin
          res_o.last    = 1'b1;
          state_o.phase = PH_IDENT;
          state_o.seen  = '0;
        end else begin
          state_o.seen = seen_inc[ByteW-1:0];
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
    // header fields always show the held values after this step
    res_o.ident = state_o.ident;
    res_o.desc  = state_o.desc;
    res_o.len   = state_o.len;
  end

endmodule

`default_nettype wire

[src/spd_checker.sv]
// Port-level checks for serial_packet_deframer_unit, plus the bind that
// attaches them. Depends on spd_pkg.
`default_nettype none

module spd_checker
  import spd_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata,
  input wire [2:0]  out_tuser,
  input wire        out_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_HEADER || out_tuser == ST_PAYLOAD
      || out_tuser == ST_EMPTY || out_tuser == ST_BAD_IDENT || out_tuser == ST_TOO_LONG))
    else $error("status code out of range");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_PAYLOAD && out_tlast
      |-> ({1'b0, out_tdata[39:32]} + 9'd1) >= {1'b0, out_tdata[23:16]})
    else $error("last payload byte before declared length");

  a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_PAYLOAD |-> out_tdata[39:24] == 16'd0)
    else $error("payload fields set on a non-payload result");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tlast && out_tdata[23:16] == 8'd0)
    else $error("empty packet result malformed");

endmodule

bind serial_packet_deframer_unit spd_checker u_spd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
